// ----- design/metp_pkg.sv -----
`timescale 1ns / 1ps

package metp_pkg;

    // Default sizes of the fixed-point format and the screen coordinates
    localparam int FRAC_BITS_DEF   = 24;
    localparam int SCREEN_BITS_DEF = 12;

    // Fixed widths of the value format, products, counter, step, escape limit and config port
    localparam int Q_W     = 32;
    localparam int PROD_W  = 64;
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [Q_W-1:0]     CENTER_RE_RST  = 32'd0;
    localparam logic [Q_W-1:0]     CENTER_IM_RST  = 32'd0;
    localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = 31'd83886;
    localparam logic [LIMIT_W-1:0] ESC_LIMIT_RST  = 31'd1677721600;
    localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = 16'd256;
    localparam int                 SCREEN_W_RST   = 800;
    localparam int                 SCREEN_H_RST   = 600;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_RE  = 3'd0,
        REG_CENTER_IM  = 3'd1,
        REG_PIXEL_STEP = 3'd2,
        REG_ESC_LIMIT  = 3'd3,
        REG_ITER_LIMIT = 3'd4,
        REG_SCREEN_W   = 3'd5,
        REG_SCREEN_H   = 3'd6
    } t_reg_idx;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the pixel position
        logic map_mul;   // form offset times pixel step
        logic map_add;   // add center, start z = c, count = 1
        logic square;    // form x*x, y*y, x*y
        logic update;    // write next z, advance count
        logic load_out;  // capture the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cont;      // point still inside and count below limit
    } t_dp_stat;

    // Saturate a 64-bit signed value to the 32-bit signed range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

// ----- design/mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps

// Escape-time evaluator for one pixel of a fractal view.
// Input channel: i_pixel_x / i_pixel_y, transferred when i_valid is high and
// o_stall is low. Output channel: o_escape_count, transferred when o_valid is
// high and i_stall is low. Configuration: i_cfg_index / i_cfg_data written
// when i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high.
// Write configuration only while no pixel is in flight.
// Steps: the pixel is mapped to c (offset times step, then add center), then
// each pass of z = z^2 + c forms the three 32x32 products, then writes the
// update and does the magnitude test.
// Throughput: one pixel at a time; the next pixel is taken once the result
// is in the output register, while that result may still wait.
// Reset (i_rst_n low, synchronous) loads the register defaults and empties
// the block. A stalled result stays in place; a finished pixel waits in the
// datapath until the output register frees up, and o_stall stays high.
module mandelbrot_escape_time_pixel
    import metp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SCREEN_BITS-1:0]   i_pixel_x,
    input  logic [SCREEN_BITS-1:0]   i_pixel_y,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [COUNT_W-1:0]       o_escape_count,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic signed [Q_W-1:0] w_center_re;
    logic signed [Q_W-1:0] w_center_im;
    logic [STEP_W-1:0]     w_pixel_step;
    logic [LIMIT_W-1:0]    w_escape_limit;
    logic [COUNT_W-1:0]    w_iteration_limit;
    logic [SCREEN_BITS:0]  w_screen_width;
    logic [SCREEN_BITS:0]  w_screen_height;

    assign o_cfg_ready = 1'b1;

    metp_regs #(
        .SCREEN_BITS (SCREEN_BITS)
    ) u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_center_re       (w_center_re),
        .o_center_im       (w_center_im),
        .o_pixel_step      (w_pixel_step),
        .o_escape_limit    (w_escape_limit),
        .o_iteration_limit (w_iteration_limit),
        .o_screen_width    (w_screen_width),
        .o_screen_height   (w_screen_height)
    );

    metp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    metp_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_center_re       (w_center_re),
        .i_center_im       (w_center_im),
        .i_pixel_step      (w_pixel_step),
        .i_escape_limit    (w_escape_limit),
        .i_iteration_limit (w_iteration_limit),
        .i_screen_width    (w_screen_width),
        .i_screen_height   (w_screen_height),
        .o_escape_count    (o_escape_count)
    );

endmodule

// ----- design/metp_regs.sv -----
`timescale 1ns / 1ps

module metp_regs
    import metp_pkg::*;
#(
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic signed [Q_W-1:0]       o_center_re,
    output logic signed [Q_W-1:0]       o_center_im,
    output logic [STEP_W-1:0]           o_pixel_step,
    output logic [LIMIT_W-1:0]          o_escape_limit,
    output logic [COUNT_W-1:0]          o_iteration_limit,
    output logic [SCREEN_BITS:0]        o_screen_width,
    output logic [SCREEN_BITS:0]        o_screen_height
);

    logic signed [Q_W-1:0] r_center_re;
    logic signed [Q_W-1:0] r_center_im;
    logic [STEP_W-1:0]     r_pixel_step;
    logic [LIMIT_W-1:0]    r_escape_limit;
    logic [COUNT_W-1:0]    r_iteration_limit;
    logic [SCREEN_BITS:0]  r_screen_width;
    logic [SCREEN_BITS:0]  r_screen_height;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re       <= CENTER_RE_RST;
            r_center_im       <= CENTER_IM_RST;
            r_pixel_step      <= PIXEL_STEP_RST;
            r_escape_limit    <= ESC_LIMIT_RST;
            r_iteration_limit <= ITER_LIMIT_RST;
            r_screen_width    <= (SCREEN_BITS+1)'(SCREEN_W_RST);
            r_screen_height   <= (SCREEN_BITS+1)'(SCREEN_H_RST);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CENTER_RE:  r_center_re       <= i_cfg_data;
                REG_CENTER_IM:  r_center_im       <= i_cfg_data;
                REG_PIXEL_STEP: r_pixel_step      <= i_cfg_data[STEP_W-1:0];
                REG_ESC_LIMIT:  r_escape_limit    <= i_cfg_data[LIMIT_W-1:0];
                REG_ITER_LIMIT: r_iteration_limit <= i_cfg_data[COUNT_W-1:0];
                REG_SCREEN_W:   r_screen_width    <= i_cfg_data[SCREEN_BITS:0];
                REG_SCREEN_H:   r_screen_height   <= i_cfg_data[SCREEN_BITS:0];
                default: ;
            endcase
        end
    end

    assign o_center_re       = r_center_re;
    assign o_center_im       = r_center_im;
    assign o_pixel_step      = r_pixel_step;
    assign o_escape_limit    = r_escape_limit;
    assign o_iteration_limit = r_iteration_limit;
    assign o_screen_width    = r_screen_width;
    assign o_screen_height   = r_screen_height;

endmodule

// ----- design/metp_dp.sv -----
`timescale 1ns / 1ps

module metp_dp
    import metp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                        i_clk,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic [SCREEN_BITS-1:0]      i_pixel_x,
    input  logic [SCREEN_BITS-1:0]      i_pixel_y,
    input  logic signed [Q_W-1:0]       i_center_re,
    input  logic signed [Q_W-1:0]       i_center_im,
    input  logic [STEP_W-1:0]           i_pixel_step,
    input  logic [LIMIT_W-1:0]          i_escape_limit,
    input  logic [COUNT_W-1:0]          i_iteration_limit,
    input  logic [SCREEN_BITS:0]        i_screen_width,
    input  logic [SCREEN_BITS:0]        i_screen_height,
    output logic [COUNT_W-1:0]          o_escape_count
);

    localparam int D_W   = SCREEN_BITS + 2;
    localparam int MAP_W = SCREEN_BITS + 34;
    localparam int MAG_W = PROD_W - FRAC_BITS;

    logic [SCREEN_BITS-1:0]      r_px;
    logic [SCREEN_BITS-1:0]      r_py;
    logic signed [MAP_W-1:0]     r_mre;
    logic signed [MAP_W-1:0]     r_mim;
    logic signed [Q_W-1:0]       r_cre;
    logic signed [Q_W-1:0]       r_cim;
    logic signed [Q_W-1:0]       r_x;
    logic signed [Q_W-1:0]       r_y;
    logic signed [PROD_W-1:0]    r_xx;
    logic signed [PROD_W-1:0]    r_yy;
    logic signed [PROD_W-1:0]    r_xy;
    logic [COUNT_W-1:0]          r_count;
    logic [COUNT_W-1:0]          r_result;

    logic signed [D_W-1:0]       w_dx;
    logic signed [D_W-1:0]       w_dy;
    logic signed [Q_W-1:0]       w_step;
    logic signed [MAP_W-1:0]     w_mre;
    logic signed [MAP_W-1:0]     w_mim;
    logic signed [PROD_W-1:0]    w_cre_sum;
    logic signed [PROD_W-1:0]    w_cim_sum;
    logic signed [PROD_W-1:0]    w_xx;
    logic signed [PROD_W-1:0]    w_yy;
    logic signed [PROD_W-1:0]    w_xy;
    logic signed [PROD_W-1:0]    w_diff;
    logic signed [PROD_W-1:0]    w_re_sum;
    logic signed [PROD_W-1:0]    w_im_sum;
    logic [PROD_W-1:0]           w_sq_sum;
    logic [MAG_W-1:0]            w_mag;
    logic                        w_below;

    // Offset of the pixel from the screen middle, times the step
    assign w_dx   = $signed({2'b00, r_px}) - $signed({2'b00, i_screen_width[SCREEN_BITS:1]});
    assign w_dy   = $signed({2'b00, r_py}) - $signed({2'b00, i_screen_height[SCREEN_BITS:1]});
    assign w_step = $signed({1'b0, i_pixel_step});
    assign w_mre  = MAP_W'(w_dx) * MAP_W'(w_step);
    assign w_mim  = MAP_W'(w_dy) * MAP_W'(w_step);

    // Add the view center
    assign w_cre_sum = PROD_W'(r_mre) + PROD_W'(i_center_re);
    assign w_cim_sum = PROD_W'(r_mim) + PROD_W'(i_center_im);

    // Squares and cross product of the current z, full 32x32 products
    assign w_xx = PROD_W'(r_x) * PROD_W'(r_x);
    assign w_yy = PROD_W'(r_y) * PROD_W'(r_y);
    assign w_xy = PROD_W'(r_x) * PROD_W'(r_y);

    // Next z: floor shifts, add c, saturate
    assign w_diff   = r_xx - r_yy;
    assign w_re_sum = (w_diff >>> FRAC_BITS) + PROD_W'(r_cre);
    assign w_im_sum = (r_xy >>> (FRAC_BITS - 1)) + PROD_W'(r_cim);

    // Squared magnitude of the current z against the escape limit
    assign w_sq_sum = $unsigned(r_xx) + $unsigned(r_yy);
    assign w_mag    = w_sq_sum[PROD_W-1:FRAC_BITS];
    assign w_below  = w_mag < MAG_W'(i_escape_limit);

    assign o_stat.cont = w_below && (r_count < i_iteration_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.map_mul) begin
            r_mre <= w_mre;
            r_mim <= w_mim;
        end
        if (i_cmd.map_add) begin
            r_cre   <= sat_q(w_cre_sum);
            r_cim   <= sat_q(w_cim_sum);
            r_x     <= sat_q(w_cre_sum);
            r_y     <= sat_q(w_cim_sum);
            r_count <= COUNT_W'(1);
        end
        if (i_cmd.square) begin
            r_xx <= w_xx;
            r_yy <= w_yy;
            r_xy <= w_xy;
        end
        if (i_cmd.update) begin
            r_x     <= sat_q(w_re_sum);
            r_y     <= sat_q(w_im_sum);
            r_count <= r_count + COUNT_W'(1);
        end
        // Escaped points report the count, bounded points report zero
        if (i_cmd.load_out) begin
            r_result <= w_below ? '0 : r_count;
        end
    end

    assign o_escape_count = r_result;

endmodule

// ----- design/metp_ctrl.sv -----
`timescale 1ns / 1ps

module metp_ctrl
    import metp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MAP_MUL = 6'b000010,
        S_MAP_ADD = 6'b000100,
        S_SQUARE  = 6'b001000,
        S_CHECK   = 6'b010000,
        S_HOLD    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Output register can take a result when empty or being drained
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAP_MUL;
                end
            end
            S_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_MAP_ADD;
            end
            S_MAP_ADD: begin
                o_cmd.map_add = 1'b1;
                n_state       = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.cont) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_SQUARE;
                end else if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                // Products stay put, so the result is still at hand
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set on a new result, clear once the receiver takes it
    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- tb/mandelbrot_escape_time_pixel_checker.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_checker
    import metp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [SCREEN_BITS_DEF-1:0] i_pixel_x,
    input  logic [SCREEN_BITS_DEF-1:0] i_pixel_y,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [COUNT_W-1:0]         i_escape_count,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int     FRAC = FRAC_BITS_DEF;
    localparam int     SB   = SCREEN_BITS_DEF;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct {
        logic [SB-1:0]      px;
        logic [SB-1:0]      py;
        logic [COUNT_W-1:0] count;
    } pixel_count_t;

    // Shadow copy of the view registers
    longint          center_re_q;
    longint          center_im_q;
    longint unsigned step_q;
    longint unsigned esc_limit_q;
    longint unsigned iter_limit_q;
    longint unsigned width_q;
    longint unsigned height_q;

    pixel_count_t awaited_counts[$];
    int           mismatches = 0;
    int           awaited_n  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaited_n;

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) begin
            return Q_HI;
        end
        if (v < Q_LO) begin
            return Q_LO;
        end
        return v;
    endfunction

    // Squared magnitude, exact as unsigned 64 bits, then dropped to the Q format
    function automatic longint unsigned magnitude_sq(input longint x, input longint y);
        longint unsigned xx;
        longint unsigned yy;
        xx = x * x;
        yy = y * y;
        return (xx + yy) >> FRAC;
    endfunction

    // Map a screen position onto one axis of the complex plane
    function automatic longint plane_coord(input logic [SB-1:0] pos,
                                           input longint unsigned size,
                                           input longint center);
        longint offset;
        offset = longint'(pos) - longint'(size >> 1);
        return clamp_q(offset * longint'(step_q) + center);
    endfunction

    function automatic logic [COUNT_W-1:0] escape_count_of(input logic [SB-1:0] px,
                                                           input logic [SB-1:0] py);
        longint          c_re;
        longint          c_im;
        longint          x;
        longint          y;
        longint          next_x;
        longint          next_y;
        longint unsigned mag;
        longint unsigned count;
        c_re  = plane_coord(px, width_q, center_re_q);
        c_im  = plane_coord(py, height_q, center_im_q);
        x     = c_re;
        y     = c_im;
        count = 1;
        mag   = magnitude_sq(x, y);
        // Iterate z = z^2 + c with floor shifts and saturation
        while (mag < esc_limit_q && count < iter_limit_q) begin
            next_x = clamp_q(((x * x - y * y) >>> FRAC) + c_re);
            next_y = clamp_q(((x * y) >>> (FRAC - 1)) + c_im);
            x      = next_x;
            y      = next_y;
            mag    = magnitude_sq(x, y);
            count++;
        end
        return (mag < esc_limit_q) ? '0 : count[COUNT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        pixel_count_t got;
        pixel_count_t want;
        if (!i_rst_n) begin
            // Load register defaults and drop anything in flight
            center_re_q  = longint'($signed(CENTER_RE_RST));
            center_im_q  = longint'($signed(CENTER_IM_RST));
            step_q       = PIXEL_STEP_RST;
            esc_limit_q  = ESC_LIMIT_RST;
            iter_limit_q = ITER_LIMIT_RST;
            width_q      = SCREEN_W_RST;
            height_q     = SCREEN_H_RST;
            awaited_counts.delete();
            awaited_n <= 0;
        end else begin
            // Compare each result transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (awaited_counts.size() == 0) begin
                    $error("escape_count: expected none, actual %0d", i_escape_count);
                    mismatches++;
                end else begin
                    want = awaited_counts.pop_front();
                    if (i_escape_count !== want.count) begin
                        $error("escape_count: expected %0d, actual %0d (pixel %0d,%0d)",
                               want.count, i_escape_count, want.px, want.py);
                        mismatches++;
                    end
                end
            end
            // Predict on each pixel transfer
            if (i_in_valid && !i_in_stall) begin
                got.px    = i_pixel_x;
                got.py    = i_pixel_y;
                got.count = escape_count_of(i_pixel_x, i_pixel_y);
                awaited_counts.push_back(got);
            end
            // Track register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_RE:  center_re_q  = longint'($signed(i_cfg_data));
                    REG_CENTER_IM:  center_im_q  = longint'($signed(i_cfg_data));
                    REG_PIXEL_STEP: step_q       = i_cfg_data[STEP_W-1:0];
                    REG_ESC_LIMIT:  esc_limit_q  = i_cfg_data[LIMIT_W-1:0];
                    REG_ITER_LIMIT: iter_limit_q = i_cfg_data[COUNT_W-1:0];
                    REG_SCREEN_W:   width_q      = i_cfg_data[SB:0];
                    REG_SCREEN_H:   height_q     = i_cfg_data[SB:0];
                    default: begin
                    end
                endcase
            end
            awaited_n <= awaited_counts.size();
        end
    end

endmodule

// ----- tb/mandelbrot_escape_time_pixel_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
    import metp_pkg::*;

    localparam int                   SB          = SCREEN_BITS_DEF;
    localparam int                   QUIET_LIMIT = 400000;
    localparam int                   PIXEL_GOAL  = 820;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

    typedef struct {
        logic [Q_W-1:0]     center_re;
        logic [Q_W-1:0]     center_im;
        logic [STEP_W-1:0]  step;
        logic [LIMIT_W-1:0] esc_limit;
        logic [COUNT_W-1:0] iter_limit;
        logic [SB:0]        width;
        logic [SB:0]        height;
    } view_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic [SB-1:0]         i_pixel_x      = '0;
    logic [SB-1:0]         i_pixel_y      = '0;
    logic                  i_stall        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [COUNT_W-1:0]    o_escape_count;
    logic                  o_cfg_ready;

    int mismatch_total;
    int results_pending;
    int pixels_sent  = 0;
    int quiet_cycles = 0;
    int stall_run    = 0;
    bit calm_phase   = 1'b0;

    always #2 i_clk = ~i_clk;

    mandelbrot_escape_time_pixel uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    mandelbrot_escape_time_pixel_checker escape_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (mismatch_total),
        .o_pending      (results_pending)
    );

    // Mostly short gaps, a few long ones, none in a calm phase
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 45) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // Result-side backpressure in runs of random length
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
        end else if (calm_phase || $urandom_range(0, 2) != 0) begin
            i_stall   <= 1'b0;
            stall_run = $urandom_range(0, 8);
        end else begin
            i_stall   <= 1'b1;
            stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 60);
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("mandelbrot_escape_time_pixel_tb NOT OK");
            $finish;
        end
    end

    // Present one pixel and hold it until transfer; valid stays high afterwards
    task automatic send_pixel(input logic [SB-1:0] px, input logic [SB-1:0] py);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Drop valid and wait until every predicted result has been seen
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // Write all registers in one burst, junk in the unused upper bits, optionally after a write to the unused index
    task automatic program_view(input view_t v, input bit with_stray);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_DATA_W-1:0] keep [7];
        t_reg_idx              idx;
        vals[int'(REG_CENTER_RE)]  = v.center_re;
        vals[int'(REG_CENTER_IM)]  = v.center_im;
        vals[int'(REG_PIXEL_STEP)] = {1'b0, v.step};
        vals[int'(REG_ESC_LIMIT)]  = {1'b0, v.esc_limit};
        vals[int'(REG_ITER_LIMIT)] = {16'd0, v.iter_limit};
        vals[int'(REG_SCREEN_W)]   = 32'(v.width);
        vals[int'(REG_SCREEN_H)]   = 32'(v.height);
        keep = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h0000_FFFF, 32'h0000_1FFF, 32'h0000_1FFF};
        i_cfg_valid <= 1'b1;
        if (with_stray) begin
            i_cfg_index <= REG_UNUSED;
            i_cfg_data  <= $urandom;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        idx = idx.first;
        forever begin
            i_cfg_index <= idx;
            i_cfg_data  <= vals[int'(idx)] | ($urandom & ~keep[int'(idx)]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (idx == idx.last) break;
            idx = idx.next;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic view_t reset_view();
        view_t v;
        v.center_re  = CENTER_RE_RST;
        v.center_im  = CENTER_IM_RST;
        v.step       = PIXEL_STEP_RST;
        v.esc_limit  = ESC_LIMIT_RST;
        v.iter_limit = ITER_LIMIT_RST;
        v.width      = (SB + 1)'(SCREEN_W_RST);
        v.height     = (SB + 1)'(SCREEN_H_RST);
        return v;
    endfunction

    // Mostly a sensible view around the set, sometimes anything the fields hold
    function automatic view_t random_view();
        view_t v;
        int    r;
        int    w;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            v.center_re = 32'($urandom_range(0, 1 << 26) - (1 << 25));
            v.center_im = 32'($urandom_range(0, 1 << 26) - (1 << 25));
        end else begin
            v.center_re = $urandom;
            v.center_im = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v.width  = (SB + 1)'($urandom_range(16, 1024));
            v.height = (SB + 1)'($urandom_range(16, 1024));
        end else if (r < 85) begin
            v.width  = (SB + 1)'($urandom_range(1, 15));
            v.height = (SB + 1)'($urandom_range(1, 15));
        end else begin
            v.width  = (SB + 1)'($urandom_range(1, 8191));
            v.height = (SB + 1)'($urandom_range(1, 8191));
        end
        w = (v.width == 0) ? 1 : int'(v.width);
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v.step = STEP_W'($urandom_range(1, (1 << 26) / w));
        end else if (r < 90) begin
            v.step = STEP_W'($urandom_range(0, 1000));
        end else begin
            v.step = STEP_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v.esc_limit = LIMIT_W'(1 << 26);
        end else if (r < 90) begin
            v.esc_limit = LIMIT_W'($urandom_range(0, 1 << 28));
        end else begin
            v.esc_limit = LIMIT_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            v.iter_limit = COUNT_W'($urandom_range(1, 64));
        end else if (r < 90) begin
            v.iter_limit = COUNT_W'($urandom_range(65, 300));
        end else begin
            v.iter_limit = COUNT_W'($urandom_range(0, 3));
        end
        return v;
    endfunction

    initial begin
        view_t         v;
        int            batch;
        int            x_top;
        int            y_top;
        logic [SB-1:0] px;
        logic [SB-1:0] py;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset view: corners, screen center (never escapes), bit patterns
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd400, 12'd300);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd399, 12'd299);
        wait_idle();

        // No iteration pass at all: escaped c gives one, else zero
        v = reset_view();
        v.iter_limit = '0;
        program_view(v, 1'b1);
        send_pixel(12'd400, 12'd300);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();

        // Zero escape threshold: every point escapes at once
        v = reset_view();
        v.esc_limit = '0;
        program_view(v, 1'b0);
        send_pixel(12'd400, 12'd300);
        send_pixel(12'd0, 12'd0);
        wait_idle();

        // Zero step: every pixel lands on the center
        v = reset_view();
        v.step      = '0;
        v.center_re = 32'hFF00_0000;
        v.center_im = 32'h0040_0000;
        program_view(v, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();

        // Register extremes drive the mapping into saturation
        v.center_re  = 32'h7FFF_FFFF;
        v.center_im  = 32'h8000_0000;
        v.step       = '1;
        v.esc_limit  = '1;
        v.iter_limit = '1;
        v.width      = '1;
        v.height     = (SB + 1)'(1);
        program_view(v, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();

        // Longest run: a point inside the set at the largest iteration limit
        v = reset_view();
        v.iter_limit = '1;
        program_view(v, 1'b0);
        send_pixel(12'd400, 12'd300);
        wait_idle();

        // Limit of one and a one-pixel screen
        v.iter_limit = COUNT_W'(1);
        v.width      = (SB + 1)'(1);
        v.height     = (SB + 1)'(1);
        program_view(v, 1'b1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();

        // Random views, each with a batch of pixels
        while (pixels_sent < PIXEL_GOAL) begin
            v = random_view();
            program_view(v, $urandom_range(0, 3) == 0);
            calm_phase = ($urandom_range(0, 3) == 0);
            x_top = (v.width > 4096) ? 4095 : ((v.width == 0) ? 0 : int'(v.width) - 1);
            y_top = (v.height > 4096) ? 4095 : ((v.height == 0) ? 0 : int'(v.height) - 1);
            batch = $urandom_range(20, 60);
            repeat (batch) begin
                if ($urandom_range(0, 6) == 0) begin
                    px = SB'($urandom);
                    py = SB'($urandom);
                end else begin
                    px = SB'($urandom_range(0, x_top));
                    py = SB'($urandom_range(0, y_top));
                end
                send_pixel(px, py);
            end
            wait_idle();
            calm_phase = 1'b0;
        end

        // Let any stray result show up before the verdict
        repeat (600) @(posedge i_clk);
        if (mismatch_total == 0) begin
            $display("mandelbrot_escape_time_pixel_tb OK");
        end else begin
            $display("mandelbrot_escape_time_pixel_tb NOT OK");
        end
        $finish;
    end

endmodule
